// ----- src/hbce_pkg.sv -----
package hbce_pkg;

    localparam int KIND_W  = 4;
    localparam int DELTA_W = 9;
    localparam int CH_W    = 8;
    localparam int COLOR_W = 3 * CH_W;
    localparam int WORD_W  = 32;
    localparam int DIV_W   = 2 * CH_W;
    localparam int NUM_W   = 14;

    localparam logic [CH_W-1:0] LIMIT_RESET  = 8'h96;
    localparam logic [CH_W-1:0] HUE_RESET    = 8'd127;
    localparam logic [CH_W-1:0] SAT_RESET    = 8'd255;
    localparam logic [CH_W-1:0] BRIGHT_RESET = 8'd0;
    localparam logic [CH_W-1:0] HUE_SECTOR   = 8'd43;
    localparam logic [CH_W-1:0] HUE_BASE_G   = 8'd85;
    localparam logic [CH_W-1:0] HUE_BASE_B   = 8'd171;
    localparam logic [CH_W-1:0] REM_SCALE    = 8'd6;

    typedef enum logic [KIND_W-1:0] {
        K_ADJ_BRIGHT = 4'd0,
        K_ADJ_HUE    = 4'd1,
        K_ADJ_SAT    = 4'd2,
        K_SET_SAT    = 4'd3,
        K_SET_BRIGHT = 4'd4,
        K_SET_HUE    = 4'd5,
        K_STEP_HUE   = 4'd6,
        K_LOAD_RGB   = 4'd7,
        K_OFF        = 4'd8,
        K_ON         = 4'd9
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_SAT,
        ST_DIV_HUE,
        ST_MUL_SR,
        ST_MUL_SRC,
        ST_MUL_P,
        ST_MUL_Q,
        ST_MUL_T,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MS_SR,
        MS_SRC,
        MS_P,
        MS_Q,
        MS_T
    } t_mul_step;

    typedef struct packed {
        logic      capture;
        logic      update;
        logic      div_start;
        logic      div_hue;
        logic      sat_wr;
        logic      hue_wr;
        logic      mul_en;
        t_mul_step mul_step;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  div_done;
        logic  mx_zero;
        logic  span_zero;
    } t_stat;

endpackage

// ----- src/hbce_in_if.sv -----
interface hbce_in_if;
    import hbce_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [DELTA_W-1:0] delta;
    logic [CH_W-1:0]           level;
    logic [COLOR_W-1:0]        color_in;

    modport source (output valid, kind, delta, level, color_in, input ready);
    modport sink (input valid, kind, delta, level, color_in, output ready);
endinterface

// ----- src/hbce_out_if.sv -----
interface hbce_out_if;
    import hbce_pkg::*;

    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [WORD_W-1:0] pixel_word;
    logic [CH_W-1:0]   hue_now;
    logic [CH_W-1:0]   saturation_now;
    logic [CH_W-1:0]   brightness_now;

    modport source (output valid, red, green, blue, pixel_word, hue_now, saturation_now,
                    brightness_now, input ready);
    modport sink (input valid, red, green, blue, pixel_word, hue_now, saturation_now,
                  brightness_now, output ready);
endinterface

// ----- src/hbce_div.sv -----
module hbce_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hbce_pkg::DIV_W-1:0] i_dividend,
    input  logic [hbce_pkg::CH_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [hbce_pkg::DIV_W-1:0] o_quot
);
    import hbce_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CH_W-1:0]  r_rem, n_rem;
    logic [CH_W-1:0]  r_dvs, n_dvs;
    logic [DIV_W-1:0] r_work, n_work;
    logic [CH_W:0]    rem_sh;
    logic             ge;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_sh = {r_rem, r_work[DIV_W-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_work = r_work;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_work = i_dividend;
        end else if (r_busy) begin
            n_rem  = ge ? CH_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[CH_W-1:0];
            n_work = {r_work[DIV_W-2:0], ge};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_work <= n_work;
    end

    assign o_done = r_done;
    assign o_quot = r_work;
endmodule

// ----- src/hbce_dp.sv -----
module hbce_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  hbce_pkg::t_cmd                     i_cmd,
    output hbce_pkg::t_stat                    o_stat,
    input  logic                               i_cfg_we,
    input  logic [hbce_pkg::CH_W-1:0]          i_cfg_wdata,
    input  logic [hbce_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [hbce_pkg::DELTA_W-1:0] i_delta,
    input  logic [hbce_pkg::CH_W-1:0]          i_level,
    input  logic [hbce_pkg::COLOR_W-1:0]       i_color,
    output logic [hbce_pkg::CH_W-1:0]          o_red,
    output logic [hbce_pkg::CH_W-1:0]          o_green,
    output logic [hbce_pkg::CH_W-1:0]          o_blue,
    output logic [hbce_pkg::WORD_W-1:0]        o_pixel_word,
    output logic [hbce_pkg::CH_W-1:0]          o_hue_now,
    output logic [hbce_pkg::CH_W-1:0]          o_saturation_now,
    output logic [hbce_pkg::CH_W-1:0]          o_brightness_now
);
    import hbce_pkg::*;

    // event latch
    t_kind                     r_kind;
    logic signed [DELTA_W-1:0] r_delta;
    logic [CH_W-1:0]           r_level;
    logic [COLOR_W-1:0]        r_color;

    // stored state and config
    logic [CH_W-1:0] r_limit;
    logic [CH_W-1:0] r_hue, n_hue;
    logic [CH_W-1:0] r_sat, n_sat;
    logic [CH_W-1:0] r_bright, n_bright;

    // product registers
    logic [CH_W-1:0] r_sr, r_src, r_p, r_q, r_t;

    // output holding register
    logic [CH_W-1:0] r_o_r, r_o_g, r_o_b, r_o_h, r_o_s, r_o_v;

    logic signed [DELTA_W:0] d_ext, d_rnd, d_half, b_sum, x_sum;
    logic [CH_W-1:0] cr, cg, cb, mx, mn, span;
    logic signed [CH_W:0] diff;
    logic [CH_W-1:0] mag, base;
    logic [NUM_W-1:0] num;
    logic [DIV_W-1:0] sat_num, div_dividend, div_quot;
    logic [CH_W-1:0] div_divisor, q8, hue_div;
    logic div_done;
    logic [2:0] region;
    logic [CH_W-1:0] region_base, rem;
    logic [CH_W-1:0] mul_a, mul_b;
    logic [DIV_W-1:0] prod;
    logic [CH_W-1:0] f_r, f_g, f_b;

    // rgb to hsv front end
    always_comb begin
        cr   = r_color[COLOR_W-1 -: CH_W];
        cg   = r_color[CH_W +: CH_W];
        cb   = r_color[CH_W-1:0];
        mn   = (cr < cg) ? ((cr < cb) ? cr : cb) : ((cg < cb) ? cg : cb);
        mx   = (cr > cg) ? ((cr > cb) ? cr : cb) : ((cg > cb) ? cg : cb);
        span = mx - mn;
        if (mx == cr) begin
            diff = $signed({1'b0, cg}) - $signed({1'b0, cb});
            base = '0;
        end else if (mx == cg) begin
            diff = $signed({1'b0, cb}) - $signed({1'b0, cr});
            base = HUE_BASE_G;
        end else begin
            diff = $signed({1'b0, cr}) - $signed({1'b0, cg});
            base = HUE_BASE_B;
        end
        mag     = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
        num     = NUM_W'(mag) * NUM_W'(HUE_SECTOR);
        sat_num = {span, {CH_W{1'b0}}} - DIV_W'(span);
        div_dividend = i_cmd.div_hue ? DIV_W'(num) : sat_num;
        div_divisor  = i_cmd.div_hue ? span : mx;
        q8      = div_quot[CH_W-1:0];
        hue_div = base + (diff[CH_W] ? CH_W'(~q8 + 1'b1) : q8);
    end

    hbce_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // state update per event
    always_comb begin
        d_ext  = {r_delta[DELTA_W-1], r_delta};
        d_rnd  = d_ext + (DELTA_W+1)'(r_delta[DELTA_W-1]);
        d_half = d_rnd >>> 1;
        b_sum  = $signed({2'b00, r_bright}) + d_half;
        x_sum  = '0;
        n_hue    = r_hue;
        n_sat    = r_sat;
        n_bright = r_bright;
        if (i_cmd.update) begin
            unique case (r_kind)
                K_ADJ_BRIGHT: begin
                    if (b_sum > $signed({2'b00, r_limit})) n_bright = r_limit;
                    else if (b_sum < 0)                    n_bright = '0;
                    else                                   n_bright = b_sum[CH_W-1:0];
                end
                K_ADJ_HUE: begin
                    x_sum = $signed({2'b00, r_hue}) + d_ext;
                    if (x_sum > 255)    n_hue = '0;
                    else if (x_sum < 0) n_hue = '1;
                    else                n_hue = x_sum[CH_W-1:0];
                end
                K_ADJ_SAT: begin
                    x_sum = $signed({2'b00, r_sat}) + d_ext;
                    if (x_sum > 255)    n_sat = '1;
                    else if (x_sum < 0) n_sat = '0;
                    else                n_sat = x_sum[CH_W-1:0];
                end
                K_SET_SAT:    n_sat    = r_level;
                K_SET_BRIGHT: n_bright = (r_level > r_limit) ? r_limit : r_level;
                K_SET_HUE:    n_hue    = r_level;
                K_STEP_HUE:   n_hue    = r_hue + 1'b1;
                K_LOAD_RGB: begin
                    // hue and saturation are refined by the divider when needed
                    n_bright = mx;
                    n_hue    = '0;
                    n_sat    = '0;
                end
                default: ;
            endcase
        end
        if (i_cmd.sat_wr) n_sat = q8;
        if (i_cmd.hue_wr) n_hue = hue_div;
    end

    // hsv to rgb: sector and scaled remainder
    always_comb begin
        if (r_hue >= 8'd215)      region = 3'd5;
        else if (r_hue >= 8'd172) region = 3'd4;
        else if (r_hue >= 8'd129) region = 3'd3;
        else if (r_hue >= 8'd86)  region = 3'd2;
        else if (r_hue >= 8'd43)  region = 3'd1;
        else                      region = 3'd0;
        region_base = CH_W'(region) * HUE_SECTOR;
        rem         = CH_W'((r_hue - region_base) * REM_SCALE);
    end

    // shared 8x8 multiplier, one product per step
    always_comb begin
        unique case (i_cmd.mul_step)
            MS_SR:   begin mul_a = r_sat;    mul_b = rem;    end
            MS_SRC:  begin mul_a = r_sat;    mul_b = ~rem;   end
            MS_P:    begin mul_a = r_bright; mul_b = ~r_sat; end
            MS_Q:    begin mul_a = r_bright; mul_b = ~r_sr;  end
            MS_T:    begin mul_a = r_bright; mul_b = ~r_src; end
            default: begin mul_a = '0;       mul_b = '0;     end
        endcase
        prod = DIV_W'(mul_a) * DIV_W'(mul_b);
    end

    // final colour select
    always_comb begin
        if (r_kind == K_OFF) begin
            f_r = '0; f_g = '0; f_b = '0;
        end else if (r_kind == K_LOAD_RGB) begin
            f_r = cr; f_g = cg; f_b = cb;
        end else if (r_sat == '0) begin
            f_r = r_bright; f_g = r_bright; f_b = r_bright;
        end else begin
            case (region)
                3'd0:    begin f_r = r_bright; f_g = r_t;      f_b = r_p;      end
                3'd1:    begin f_r = r_q;      f_g = r_bright; f_b = r_p;      end
                3'd2:    begin f_r = r_p;      f_g = r_bright; f_b = r_t;      end
                3'd3:    begin f_r = r_p;      f_g = r_q;      f_b = r_bright; end
                3'd4:    begin f_r = r_t;      f_g = r_p;      f_b = r_bright; end
                default: begin f_r = r_bright; f_g = r_p;      f_b = r_q;      end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RESET;
            r_hue    <= HUE_RESET;
            r_sat    <= SAT_RESET;
            r_bright <= BRIGHT_RESET;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            r_hue    <= n_hue;
            r_sat    <= n_sat;
            r_bright <= n_bright;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= t_kind'(i_kind);
            r_delta <= i_delta;
            r_level <= i_level;
            r_color <= i_color;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_step)
                MS_SR:   r_sr  <= prod[DIV_W-1:CH_W];
                MS_SRC:  r_src <= prod[DIV_W-1:CH_W];
                MS_P:    r_p   <= prod[DIV_W-1:CH_W];
                MS_Q:    r_q   <= prod[DIV_W-1:CH_W];
                default: r_t   <= prod[DIV_W-1:CH_W];
            endcase
        end
        if (i_cmd.out_load) begin
            r_o_r <= f_r;
            r_o_g <= f_g;
            r_o_b <= f_b;
            r_o_h <= r_hue;
            r_o_s <= r_sat;
            r_o_v <= r_bright;
        end
    end

    assign o_stat.kind      = r_kind;
    assign o_stat.div_done  = div_done;
    assign o_stat.mx_zero   = (mx == '0);
    assign o_stat.span_zero = (span == '0);

    assign o_red            = r_o_r;
    assign o_green          = r_o_g;
    assign o_blue           = r_o_b;
    assign o_pixel_word     = {r_o_g, r_o_r, r_o_b, {CH_W{1'b0}}};
    assign o_hue_now        = r_o_h;
    assign o_saturation_now = r_o_s;
    assign o_brightness_now = r_o_v;
endmodule

// ----- src/hbce_ctrl.sv -----
module hbce_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  hbce_pkg::t_stat i_stat,
    output hbce_pkg::t_cmd  o_cmd
);
    import hbce_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (i_stat.kind == K_LOAD_RGB) n_state = i_stat.mx_zero ? ST_DONE : ST_DIV_SAT;
                else if (i_stat.kind == K_OFF) n_state = ST_DONE;
                else                           n_state = ST_MUL_SR;
            end
            ST_DIV_SAT: begin
                if (i_stat.div_done) n_state = i_stat.span_zero ? ST_DONE : ST_DIV_HUE;
            end
            ST_DIV_HUE: if (i_stat.div_done) n_state = ST_DONE;
            ST_MUL_SR:  n_state = ST_MUL_SRC;
            ST_MUL_SRC: n_state = ST_MUL_P;
            ST_MUL_P:   n_state = ST_MUL_Q;
            ST_MUL_Q:   n_state = ST_MUL_T;
            ST_MUL_T:   n_state = ST_DONE;
            ST_DONE:    if (slot_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_step = MS_SR;
        o_in_ready     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_UPDATE: begin
                o_cmd.update    = 1'b1;
                o_cmd.div_start = (i_stat.kind == K_LOAD_RGB) && !i_stat.mx_zero;
            end
            ST_DIV_SAT: begin
                o_cmd.sat_wr    = i_stat.div_done;
                o_cmd.div_start = i_stat.div_done && !i_stat.span_zero;
                o_cmd.div_hue   = 1'b1;
            end
            ST_DIV_HUE: begin
                o_cmd.hue_wr  = i_stat.div_done;
                o_cmd.div_hue = 1'b1;
            end
            ST_MUL_SR:  begin o_cmd.mul_en = 1'b1; o_cmd.mul_step = MS_SR;  end
            ST_MUL_SRC: begin o_cmd.mul_en = 1'b1; o_cmd.mul_step = MS_SRC; end
            ST_MUL_P:   begin o_cmd.mul_en = 1'b1; o_cmd.mul_step = MS_P;   end
            ST_MUL_Q:   begin o_cmd.mul_en = 1'b1; o_cmd.mul_step = MS_Q;   end
            ST_MUL_T:   begin o_cmd.mul_en = 1'b1; o_cmd.mul_step = MS_T;   end
            ST_DONE:    o_cmd.out_load = slot_free;
            default: ;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load)  n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else                 n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// ----- src/hsv_backlight_color_engine.sv -----
// hsv events pass through the shared multiplier steps, off goes straight to done,
// load rgb runs two bit-serial divider passes; a gray load skips the hue pass, a black load both
// a new event is taken only once the last is through, as sequencing runs on the shared multiplier
// steps and the bit-serial divider; a result not yet taken holds the next in done
// reset (synchronous, active low): hue 127, saturation 255, brightness 0, limit 150
module hsv_backlight_color_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hbce_pkg::CH_W-1:0]     i_cfg_wdata,
    hbce_in_if.sink                       i_evt,
    hbce_out_if.source                    o_res
);
    import hbce_pkg::*;

    // command and status between controller and datapath
    t_cmd  w_cmd;
    t_stat w_stat;

    // controller: event sequencing and output slot handshake
    hbce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_evt.valid),
        .o_in_ready  (i_evt.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: stored hsv, limit register, multiplier, divider, result register
    hbce_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_kind           (i_evt.kind),
        .i_delta          (i_evt.delta),
        .i_level          (i_evt.level),
        .i_color          (i_evt.color_in),
        .o_red            (o_res.red),
        .o_green          (o_res.green),
        .o_blue           (o_res.blue),
        .o_pixel_word     (o_res.pixel_word),
        .o_hue_now        (o_res.hue_now),
        .o_saturation_now (o_res.saturation_now),
        .o_brightness_now (o_res.brightness_now)
    );

    // one event in flight: an accepted transaction closes the input until done
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt.valid && i_evt.ready) |=> !i_evt.ready)
        else $error("input accepted while an event is in flight");

    // the result register is only overwritten when its content is gone
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_res.valid || o_res.ready))
        else $error("pending result overwritten");

    // hue from the divider is taken only on its completion
    a_hue_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.hue_wr |-> w_stat.div_done)
        else $error("hue written before divider finished");
endmodule
